### rtl/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types and constants of the variable-size ring allocator.
// ----------------------------------------------------------------------------
package vra_pkg;

  // Ring geometry. RING_BYTES is a power of two, so offsets wrap by truncation.
  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 8;
  localparam int OFF_W        = $clog2(RING_BYTES);
  localparam int CALC_W       = OFF_W + 2;

  // Field widths of the stream words
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 10;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_READY = 2'd2,
    KIND_SKIP  = 2'd3
  } entry_kind_e;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_GET     = 2'd2,
    OP_FREE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_WRONG    = 2'd3
  } status_e;

  // One header entry: payload span and record kind
  typedef struct packed {
    entry_kind_e       kind;
    logic [SIZE_W-1:0] span;
  } hdr_t;

  // Placement decision for an allocate request
  typedef struct packed {
    logic              ok;
    logic              wrap;
    logic [SIZE_W-1:0] skip_span;
    logic [OFF_W-1:0]  alloc_at;
    logic [OFF_W-1:0]  next_tail;
    logic [POS_W-1:0]  pos;
  } place_t;

endpackage

### rtl/vra_place.sv
// ----------------------------------------------------------------------------
// vra_place
// Decide where an allocate request lands in the ring, and whether it wraps.
// ----------------------------------------------------------------------------
module vra_place import vra_pkg::*; (
  input  logic [OFF_W-1:0]  head_i,
  input  logic [OFF_W-1:0]  tail_i,
  input  logic [SIZE_W-1:0] req_i,
  output place_t            place_o
);

  logic [CALC_W-1:0] head_w;
  logic [CALC_W-1:0] tail_w;
  logic [CALC_W-1:0] total;
  logic [CALC_W-1:0] hdr_w;
  logic [CALC_W-1:0] ring_w;
  logic [CALC_W-1:0] room_all;
  logic [CALC_W-1:0] room_top;
  logic [CALC_W-1:0] free_low;
  logic [CALC_W-1:0] gap;
  logic [CALC_W-1:0] alloc_w;
  logic              fit_end;
  logic              fit_wrap;

  always_comb begin
    head_w   = CALC_W'(head_i);
    tail_w   = CALC_W'(tail_i);
    hdr_w    = CALC_W'(HEADER_BYTES);
    ring_w   = CALC_W'(RING_BYTES);
    total    = CALC_W'(req_i) + hdr_w;
    room_all = head_w + ring_w - tail_w - CALC_W'(1);
    room_top = ring_w - tail_w;
    // space below the head when placement restarts at offset zero
    free_low = head_w - CALC_W'(1);
    fit_end  = (total <= room_top);
    fit_wrap = (head_w != '0) && (total <= free_low);
    gap      = (room_top >= hdr_w) ? (room_top - hdr_w) : '0;

    place_o = '0;
    if (tail_w >= head_w) begin
      place_o.ok   = (total <= room_all) && (fit_end || fit_wrap);
      place_o.wrap = (total <= room_all) && !fit_end && fit_wrap;
    end else begin
      place_o.ok   = (total <= head_w - tail_w - CALC_W'(1));
      place_o.wrap = 1'b0;
    end
    place_o.skip_span = SIZE_W'(gap);
    alloc_w           = place_o.wrap ? '0 : tail_w;
    place_o.alloc_at  = OFF_W'(alloc_w);
    place_o.next_tail = OFF_W'(alloc_w + total);
    place_o.pos       = POS_W'(alloc_w + hdr_w);
  end

endmodule

### rtl/variable_size_ring_allocator_unit.sv
// ----------------------------------------------------------------------------
// variable_size_ring_allocator_unit
// Header bookkeeping for a byte ring of variable-size records.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Word layout (bit 0 up)                               | Role
//  ---------+-----+------------------------------------------------------+---------------
//  s_axis   | in  | op[2], request_size[10], record_position[10], pad[2] | one request
//  m_axis   | out | status[2], payload_position[10], payload_length[10], | one response
//           |     | error_seen[1], pad[1]                                |  per request
//
// One request is handled at a time against a single-port header memory with
// registered read data, shared by every read and write. Allocate writes the
// record header, after a skip header at the tail when the record wraps; enqueue
// reads the header and rewrites an allocated one as ready; get reads the head
// header; free reads it and, when records remain, the new head header for a skip
// hop. Empty get or free, free not at the head and failed allocate skip memory.
// A new request is taken while the previous response still waits in the output
// register; a stalled output holds the block in its final state.
// Reset clears head, tail, the error flag and the handshake; the header memory
// is not cleared and holds garbage until a header is written.
// ----------------------------------------------------------------------------
module variable_size_ring_allocator_unit import vra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // op[1:0], request_size[11:2], record_position[21:12], zero[23:22]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status[1:0], payload_position[11:2], payload_length[21:12],
  // error_seen[22], zero[23]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_HOP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [OFF_W-1:0]  head_q, head_d;
  logic [OFF_W-1:0]  tail_q, tail_d;
  logic              err_q, err_d;

  // request fields, held for the whole operation
  op_e               op_q;
  logic [SIZE_W-1:0] req_q;
  logic [OFF_W-1:0]  at_q;

  // pending response
  status_e           res_status_q, res_status_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic [SIZE_W-1:0] res_len_q, res_len_d;

  // output register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  // header memory port
  hdr_t              hdr_mem [RING_BYTES];
  hdr_t              hdr_rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [OFF_W-1:0]  mem_addr;
  hdr_t              mem_wdata;

  logic              in_fire;
  logic              out_free;
  logic [POS_W-1:0]  in_pos;
  logic [OFF_W-1:0]  in_at;
  logic [OFF_W-1:0]  hop_head;
  place_t            place;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // header offset named by a payload position: step back over the header
  assign in_pos   = s_axis_tdata_i[OP_W+SIZE_W +: POS_W];
  assign in_at    = OFF_W'(in_pos) - OFF_W'(HEADER_BYTES);
  // head after releasing the current head record
  assign hop_head = head_q + OFF_W'(hdr_rd_q.span) + OFF_W'(HEADER_BYTES);

  vra_place u_place (
    .head_i  (head_q),
    .tail_i  (tail_q),
    .req_i   (req_q),
    .place_o (place)
  );

  // Sequencer: every branch does at most one memory access per cycle
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    err_d        = err_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_len_d    = res_len_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = head_q;
    mem_wdata    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = ST_OK;
        res_pos_d    = '0;
        res_len_d    = '0;
        state_d      = S_LOOK;
        case (op_q)
          OP_ALLOC: begin
            if (!place.ok) begin
              err_d        = 1'b1;
              res_status_d = ST_NO_SPACE;
              state_d      = S_DONE;
            end else if (place.wrap) begin
              // leave a skip header at the tail, place the record next cycle
              mem_we         = 1'b1;
              mem_addr       = tail_q;
              mem_wdata.kind = KIND_SKIP;
              mem_wdata.span = place.skip_span;
              state_d        = S_WRAP;
            end else begin
              mem_we         = 1'b1;
              mem_addr       = place.alloc_at;
              mem_wdata.kind = KIND_ALLOC;
              mem_wdata.span = req_q;
              tail_d         = place.next_tail;
              res_pos_d      = place.pos;
              res_len_d      = req_q;
              state_d        = S_DONE;
            end
          end
          OP_ENQUEUE: begin
            mem_re   = 1'b1;
            mem_addr = at_q;
          end
          OP_GET: begin
            if (head_q == tail_q) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              mem_re   = 1'b1;
              mem_addr = head_q;
            end
          end
          OP_FREE: begin
            if (head_q == tail_q) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else if (at_q != head_q) begin
              res_status_d = ST_WRONG;
              state_d      = S_DONE;
            end else begin
              mem_re   = 1'b1;
              mem_addr = head_q;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WRAP: begin
        mem_we         = 1'b1;
        mem_addr       = place.alloc_at;
        mem_wdata.kind = KIND_ALLOC;
        mem_wdata.span = req_q;
        tail_d         = place.next_tail;
        res_pos_d      = place.pos;
        res_len_d      = req_q;
        state_d        = S_DONE;
      end

      S_LOOK: begin
        state_d = S_DONE;
        case (op_q)
          OP_ENQUEUE: begin
            if (hdr_rd_q.kind == KIND_ALLOC) begin
              mem_we         = 1'b1;
              mem_addr       = at_q;
              mem_wdata.kind = KIND_READY;
              mem_wdata.span = hdr_rd_q.span;
            end else begin
              res_status_d = ST_WRONG;
            end
          end
          OP_GET: begin
            res_pos_d = POS_W'(head_q + OFF_W'(HEADER_BYTES));
            res_len_d = hdr_rd_q.span;
          end
          OP_FREE: begin
            if (hdr_rd_q.kind != KIND_READY) begin
              res_status_d = ST_WRONG;
            end else begin
              head_d = hop_head;
              if (hop_head != tail_q) begin
                // look at the next header for a skip marker
                mem_re   = 1'b1;
                mem_addr = hop_head;
                state_d  = S_HOP;
              end
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_HOP: begin
        if (hdr_rd_q.kind == KIND_SKIP) begin
          head_d = '0;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      err_q   <= err_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(s_axis_tdata_i[OP_W-1:0]);
      req_q <= s_axis_tdata_i[OP_W +: SIZE_W];
      at_q  <= in_at;
    end
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_len_q    <= res_len_d;
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {1'b0, err_q, res_len_q, res_pos_q, res_status_q};
    end
  end

  // header memory: one access per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hdr_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      hdr_rd_q <= hdr_mem[mem_addr];
    end
  end

endmodule
